[hw/rtl/cla_pkg.sv]
// Shared constants and codes for the command line assembler.
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

    localparam int LINE_BYTES = 64;
    localparam int IDX_W      = $clog2(LINE_BYTES);
    localparam int ADDR_W     = IDX_W + 1;

    localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(LINE_BYTES - 1);

    localparam logic [1:0] OP_RECEIVE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] ST_CHAR     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_ZERO_LEN = 2'd3;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;

endpackage

`default_nettype wire

[hw/rtl/command_line_assembler.sv]
// Command line assembler: builds terminal lines in a banked memory and streams the held line.
//
//  Channel  | Dir | tdata (low bit up)        | tuser     | tlast
//  ---------+-----+---------------------------+-----------+-----------------
//  s        | in  | data_byte[7:0], max_len   | op[1:0]   | -
//  m        | out | char_out[7:0]             | status    | last of a read
//
// A read that is refused (zero max_len or no held line) or that has a zero
// limit returns its status word in the cycle after it is accepted. A read of
// a line passes its first character through the memory read and the staging
// register, and then delivers one character per cycle while the output is not
// stalled. The memory holds two line banks; completing a line while no line is
// held swaps the bank roles, so no copy is made. Reset clears the counts and
// flags only. A stalled output holds the read sequencer and blocks new input words.
`timescale 1ns / 1ps
`default_nettype none

module command_line_assembler
    import cla_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // data_byte[7:0], max_len[15:8]
    input  wire  [1:0]  i_s_tuser,   // op[1:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // char_out[7:0]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast    // last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    logic [7:0] r_mem [2*LINE_BYTES];
    logic [7:0] r_q;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_build_cnt, n_build_cnt;
    logic [IDX_W-1:0]  r_held_cnt, n_held_cnt;
    logic              r_held_ready, n_held_ready;
    logic              r_held_bank, n_held_bank;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_limit, n_limit;
    logic              r_pend_valid, n_pend_valid;
    logic [7:0]        r_pend, n_pend;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_status, n_status;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;

    logic              out_free;
    logic              s_acc;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_pos;
    logic [1:0]        op;
    logic [7:0]        in_byte;
    logic [7:0]        max_len;
    logic [7:0]        len_m1;
    logic [7:0]        held_ext;
    logic              emit;
    logic [1:0]        e_status;
    logic [7:0]        e_char;
    logic              e_last;

    assign op       = i_s_tuser;
    assign in_byte  = i_s_tdata[7:0];
    assign max_len  = i_s_tdata[15:8];
    assign len_m1   = max_len - 8'd1;
    assign held_ext = {{(8-IDX_W){1'b0}}, r_held_cnt};

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state      = r_state;
        n_build_cnt  = r_build_cnt;
        n_held_cnt   = r_held_cnt;
        n_held_ready = r_held_ready;
        n_held_bank  = r_held_bank;
        n_pos        = r_pos;
        n_limit      = r_limit;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        wr_en        = 1'b0;
        rd_pos       = r_pos;
        emit         = 1'b0;
        e_status     = ST_CHAR;
        e_char       = 8'd0;
        e_last       = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (op)
                        OP_RECEIVE: begin
                            if (in_byte == CH_CR || in_byte == CH_LF) begin
                                if (r_build_cnt != '0) begin
                                    if (!r_held_ready) begin
                                        n_held_bank  = ~r_held_bank;
                                        n_held_cnt   = r_build_cnt;
                                        n_held_ready = 1'b1;
                                    end
                                    n_build_cnt = '0;
                                end
                            end else if (in_byte == CH_BS || in_byte == CH_DEL) begin
                                if (r_build_cnt != '0) begin
                                    n_build_cnt = r_build_cnt - IDX_W'(1);
                                end
                            end else if (r_build_cnt < CNT_MAX) begin
                                wr_en       = 1'b1;
                                n_build_cnt = r_build_cnt + IDX_W'(1);
                            end else begin
                                n_build_cnt = '0;
                            end
                        end
                        OP_READ: begin
                            if (max_len == 8'd0) begin
                                emit     = 1'b1;
                                e_status = ST_ZERO_LEN;
                            end else if (!r_held_ready) begin
                                emit     = 1'b1;
                                e_status = ST_NONE;
                            end else begin
                                n_held_ready = 1'b0;
                                n_held_cnt   = '0;
                                if (len_m1 < held_ext) begin
                                    n_limit = len_m1[IDX_W-1:0];
                                end else begin
                                    n_limit = r_held_cnt;
                                end
                                if (n_limit == '0) begin
                                    emit     = 1'b1;
                                    e_status = ST_EMPTY;
                                end else begin
                                    n_state      = S_READ;
                                    n_pos        = '0;
                                    n_pend_valid = 1'b0;
                                    rd_pos       = '0;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_build_cnt  = '0;
                            n_held_cnt   = '0;
                            n_held_ready = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    if (r_pend_valid) begin
                        emit   = 1'b1;
                        e_char = r_pend;
                        if (r_pos == r_limit || r_q == 8'd0) begin
                            n_state = S_IDLE;
                        end else begin
                            e_last = 1'b0;
                            n_pend = r_q;
                            n_pos  = r_pos + IDX_W'(1);
                            rd_pos = n_pos;
                        end
                    end else if (r_q == 8'd0) begin
                        emit     = 1'b1;
                        e_status = ST_EMPTY;
                        n_state  = S_IDLE;
                    end else begin
                        n_pend       = r_q;
                        n_pend_valid = 1'b1;
                        n_pos        = r_pos + IDX_W'(1);
                        rd_pos       = n_pos;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_ovalid = 1'b1;
            n_status = e_status;
            n_char   = e_char;
            n_last   = e_last;
        end else begin
            n_ovalid = r_ovalid && !i_m_tready;
            n_status = r_status;
            n_char   = r_char;
            n_last   = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[{~r_held_bank, r_build_cnt}] <= in_byte;
        end
        r_q <= r_mem[{n_held_bank, rd_pos}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_build_cnt  <= '0;
            r_held_cnt   <= '0;
            r_held_ready <= 1'b0;
            r_held_bank  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_build_cnt  <= n_build_cnt;
            r_held_cnt   <= n_held_cnt;
            r_held_ready <= n_held_ready;
            r_held_bank  <= n_held_bank;
            r_pend_valid <= n_pend_valid;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_limit  <= n_limit;
        r_pend   <= n_pend;
        r_status <= n_status;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_char;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

[hw/rtl/cla_checker.sv]
// Port-level checks for the command line assembler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cla_checker
    import cla_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [7:0]  o_m_tdata,
    input wire [1:0]  o_m_tuser,
    input wire        o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("Stalled output word changed.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_CHAR |-> o_m_tlast)
        else $error("Status word is not the last word of a read.");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_CHAR |-> o_m_tdata == 8'd0)
        else $error("Status word carries a character.");

    a_busy_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("Input accepted in the middle of a line read.");

endmodule

bind command_line_assembler cla_checker u_cla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the command line assembler stream interface.
`timescale 1ns / 1ps

module tb;
    import cla_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RAND_WORDS  = 140;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 16;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         NUM_ROWS    = 24;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] ch;
        logic       last;
    } t_line_res;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] b;
        logic [7:0] ml;
        logic       typed;
        logic [1:0] status;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [1:0] s_op = OP_RECEIVE;
    logic [7:0] s_byte = 8'h00;
    logic [7:0] s_ml = 8'h00;
    logic       m_ready = 1'b0;
    wire        o_s_tready;
    wire        o_m_tvalid;
    wire  [7:0] o_m_tdata;
    wire  [1:0] o_m_tuser;
    wire        o_m_tlast;

    t_line_res  expected_chars[$];
    logic [7:0] build_line [LINE_BYTES];
    logic [7:0] held_line [LINE_BYTES];
    int unsigned build_len = 0;
    int unsigned held_len = 0;
    bit         held_valid = 1'b0;
    int         mismatches = 0;
    int         words_sent = 0;
    int         send_idle_pct = 25;
    int         recv_idle_pct = 58;
    bit         hold_go = 1'b0;
    t_dir_row   directed_rows [NUM_ROWS];

    command_line_assembler dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  ({s_ml, s_byte}),
        .i_s_tuser  (s_op),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void predict_line_results(input logic [1:0] op, input logic [7:0] b,
                                                 input logic [7:0] ml, output t_line_res res[$]);
        int unsigned lim;
        int unsigned n;
        res = {};
        case (op)
            OP_RECEIVE: begin
                if (b == CH_CR || b == CH_LF) begin
                    if (build_len != 0) begin
                        if (!held_valid) begin
                            held_line = build_line;
                            held_len = build_len;
                            held_valid = 1'b1;
                        end
                        build_len = 0;
                    end
                end else if (b == CH_BS || b == CH_DEL) begin
                    if (build_len != 0) build_len--;
                end else if (build_len < LINE_BYTES - 1) begin
                    build_line[build_len] = b;
                    build_len++;
                end else begin
                    build_len = 0;
                end
            end
            OP_READ: begin
                if (ml == 8'd0) begin
                    res.push_back('{ST_ZERO_LEN, 8'h00, 1'b1});
                end else if (!held_valid) begin
                    res.push_back('{ST_NONE, 8'h00, 1'b1});
                end else begin
                    lim = ml - 1;
                    if (lim > held_len) lim = held_len;
                    n = 0;
                    while (n < lim && held_line[n] != 8'h00) n++;
                    held_valid = 1'b0;
                    held_len = 0;
                    if (n == 0) begin
                        res.push_back('{ST_EMPTY, 8'h00, 1'b1});
                    end else begin
                        for (int unsigned i = 0; i < n; i++) begin
                            res.push_back('{ST_CHAR, held_line[i], i + 1 == n});
                        end
                    end
                end
            end
            OP_CLEAR: begin
                build_len = 0;
                held_len = 0;
                held_valid = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [7:0] b, input logic [7:0] ml,
                             input logic typed = 1'b0, input logic [1:0] typed_status = ST_CHAR);
        t_line_res res[$];
        if (words_sent == 60) begin
            send_idle_pct = 58;
            recv_idle_pct = 25;
        end else if (words_sent == 120) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        predict_line_results(op, b, ml, res);
        if (typed) begin
            expected_chars.push_back('{typed_status, 8'h00, 1'b1});
        end else begin
            foreach (res[i]) expected_chars.push_back(res[i]);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_byte <= b;
        s_ml <= ml;
        do @(posedge i_clk); while (!o_s_tready);
        if (op != OP_UNUSED) words_sent++;
    endtask

    initial begin
        t_line_res got;
        t_line_res want;
        @(posedge rst_n);
        forever begin
            @(posedge i_clk);
            if (m_ready && o_m_tvalid) begin
                got = '{o_m_tuser, o_m_tdata, o_m_tlast};
                if (expected_chars.size() == 0) begin
                    $error("unexpected word: status %0d char %02h last %0b",
                           got.status, got.ch, got.last);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.ch !== want.ch) begin
                        $error("char_out: expected %02h, got %02h", want.ch, got.ch);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (hold_go) begin
                hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** command_line_assembler: FAILED **");
        $finish;
    end

    initial begin
        int rand_words;
        int pick;
        int len;
        int r;
        logic [7:0] b;
        logic [7:0] ml;
        bit hold_done;
        bit force_long;

        directed_rows = '{
            '{OP_READ,    8'h00,  8'd10,  1'b1, ST_NONE},
            '{OP_READ,    8'h00,  8'd0,   1'b1, ST_ZERO_LEN},
            '{OP_RECEIVE, CH_CR,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_BS,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'hFF,  8'hFF,  1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'h41,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_DEL, 8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'h01,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_LF,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_CR,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'h55,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_CR,  8'd0,   1'b0, ST_CHAR},
            '{OP_READ,    8'hFF,  8'd255, 1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'h00,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, 8'h42,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_CR,  8'd0,   1'b0, ST_CHAR},
            '{OP_READ,    8'h00,  8'd8,   1'b1, ST_EMPTY},
            '{OP_RECEIVE, 8'h43,  8'd0,   1'b0, ST_CHAR},
            '{OP_RECEIVE, CH_CR,  8'd0,   1'b0, ST_CHAR},
            '{OP_READ,    8'h00,  8'd1,   1'b1, ST_EMPTY},
            '{OP_RECEIVE, 8'h44,  8'd0,   1'b0, ST_CHAR},
            '{OP_UNUSED,  8'hFF,  8'hFF,  1'b0, ST_CHAR},
            '{OP_CLEAR,   8'h00,  8'd0,   1'b0, ST_CHAR},
            '{OP_READ,    8'h00,  8'd5,   1'b1, ST_NONE}
        };

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            send_word(directed_rows[i].op, directed_rows[i].b, directed_rows[i].ml,
                      directed_rows[i].typed, directed_rows[i].status);
        end

        rand_words = 0;
        hold_done = 1'b0;
        while (rand_words < RAND_WORDS) begin
            force_long = (words_sent >= 120) && !hold_done;
            pick = force_long ? 0 : $urandom_range(99);
            if (pick < 70) begin
                r = $urandom_range(99);
                if (force_long) len = 30;
                else if (r < 80) len = $urandom_range(12);
                else if (r < 95) len = $urandom_range(40, 13);
                else len = $urandom_range(66, 60);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(99);
                    if (force_long) b = 8'($urandom_range(8'h7E, 8'h21));
                    else if (r < 5) b = r[0] ? CH_BS : CH_DEL;
                    else if (r < 9) b = 8'h00;
                    else if (r < 12) b = 8'($urandom_range(255));
                    else begin
                        b = 8'($urandom_range(255));
                        if (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL) b = 8'h2A;
                    end
                    send_word(OP_RECEIVE, b, 8'($urandom_range(255)));
                end
                r = $urandom_range(99);
                send_word(OP_RECEIVE, r[0] ? CH_CR : CH_LF, 8'($urandom_range(255)));
                if (r < 20) send_word(OP_RECEIVE, r[0] ? CH_LF : CH_CR, 8'($urandom_range(255)));
                rand_words += len + 1;
                if (force_long || $urandom_range(3) != 0) begin
                    r = $urandom_range(99);
                    if (force_long || (r >= 40 && r < 70)) ml = 8'd255;
                    else if (r < 8) ml = 8'd0;
                    else if (r < 14) ml = 8'd1;
                    else if (r < 40) ml = 8'($urandom_range(10, 2));
                    else ml = 8'($urandom_range(255));
                    if (force_long) begin
                        hold_go = 1'b1;
                        hold_done = 1'b1;
                    end
                    send_word(OP_READ, 8'($urandom_range(255)), ml);
                    rand_words++;
                end
            end else if (pick < 82) begin
                send_word(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)));
                rand_words++;
            end else if (pick < 88) begin
                send_word(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
                rand_words++;
            end else if (pick < 91) begin
                send_word(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
                send_word(2'($urandom_range(3)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
                rand_words++;
            end
        end
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** command_line_assembler: PASSED **");
        end else begin
            $display("** command_line_assembler: FAILED **");
        end
        $finish;
    end

endmodule
